[hdl/conv5_pkg.sv]
// ----------------------------------------------------------------------------
// conv5_pkg
// Shared types and constants of the 5x5 zero-padded convolution stream.
// ----------------------------------------------------------------------------
package conv5_pkg;

    localparam int DEF_WIDTH  = 28;
    localparam int DEF_HEIGHT = 28;

    localparam int K         = 5;              // kernel size
    localparam int TAPS      = K * K;
    localparam int LINES     = K - 1;          // delay lines in the line memory
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 12;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ROW_SUM_W = PROD_W + 3;
    localparam int ACC_W     = 36;
    localparam int BIAS_W    = 32;
    localparam int FRAC_SH   = 10;
    localparam int CFG_W     = K * COEF_W;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF0 = 3'd0,
        REG_COEF1 = 3'd1,
        REG_COEF2 = 3'd2,
        REG_COEF3 = 3'd3,
        REG_COEF4 = 3'd4,
        REG_BIAS  = 3'd5,
        REG_RELU  = 3'd6
    } t_reg;

    typedef struct packed {
        logic         emit;
        logic         last;
        logic [K-1:0] row_mask;
        logic [K-1:0] col_mask;
    } t_meta;

    // tap r*K+c, column K-1 is the newest
    typedef logic [TAPS-1:0][SAMPLE_W-1:0] t_window;

    typedef logic [K-1:0][CFG_W-1:0] t_coef_set;

endpackage

[hdl/same_padded_conv5x5_stream.sv]
// ----------------------------------------------------------------------------
// same_padded_conv5x5_stream
// 5x5 same-size convolution with zero padding over a raster pixel stream.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  in      | in        | i_in_valid / o_in_ready   | i_kind, i_sample
//  out     | out       | o_out_valid / i_out_ready | o_value, o_last_pixel,
//          |           |                           | o_saturated
//  cfg     | in        | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// one word per cycle while o_in_ready is high; results leave from a register
// the line memory does one read and one write per cycle, columns never collide
// reset clears counters, window and config; line memory has no clearing pass,
// its unwritten entries only reach taps masked off by coordinate
// a stalled output freezes the whole pipeline, o_in_ready drops with it
// ----------------------------------------------------------------------------
module same_padded_conv5x5_stream #(
    parameter int IMAGE_WIDTH  = conv5_pkg::DEF_WIDTH,
    parameter int IMAGE_HEIGHT = conv5_pkg::DEF_HEIGHT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_kind,
    input  logic signed [conv5_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [conv5_pkg::SAMPLE_W-1:0]  o_value,
    output logic                                   o_last_pixel,
    output logic                                   o_saturated,
    input  logic                                   i_cfg_wr_en,
    input  logic [conv5_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [conv5_pkg::CFG_W-1:0]            i_cfg_data
);

    import conv5_pkg::*;

    t_coef_set                r_coef;
    logic signed [BIAS_W-1:0] r_bias;
    logic                     r_relu;

    logic    en;
    logic    win_valid;
    t_meta   meta;
    t_window window;

    assign en         = ~o_out_valid | i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
            r_bias <= '0;
            r_relu <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_COEF0: r_coef[0] <= i_cfg_data;
                REG_COEF1: r_coef[1] <= i_cfg_data;
                REG_COEF2: r_coef[2] <= i_cfg_data;
                REG_COEF3: r_coef[3] <= i_cfg_data;
                REG_COEF4: r_coef[4] <= i_cfg_data;
                REG_BIAS:  r_bias    <= i_cfg_data[BIAS_W-1:0];
                REG_RELU:  r_relu    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    conv5_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_sample    (i_sample),
        .o_win_valid (win_valid),
        .o_meta      (meta),
        .o_window    (window)
    );

    conv5_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (win_valid),
        .i_meta   (meta),
        .i_window (window),
        .i_coef   (r_coef),
        .i_bias   (r_bias),
        .i_relu   (r_relu),
        .o_valid  (o_out_valid),
        .o_value  (o_value),
        .o_last   (o_last_pixel),
        .o_sat    (o_saturated)
    );

`ifndef NO_ASSERTIONS
    a_relu_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_relu |-> !o_value[SAMPLE_W-1])
        else $error("negative value with relu on");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_value == 16'sh7fff || o_value == 16'sh8000 || o_value == 16'sh0000))
        else $error("saturated flag without a clipped value");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule

[hdl/conv5_ram.sv]
// ----------------------------------------------------------------------------
// conv5_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module conv5_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 28
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/conv5_front.sv]
// ----------------------------------------------------------------------------
// conv5_front
// Frame counters, line memory read-modify-write and the 5x5 tap window.
// ----------------------------------------------------------------------------
module conv5_front #(
    parameter int IMAGE_WIDTH  = conv5_pkg::DEF_WIDTH,
    parameter int IMAGE_HEIGHT = conv5_pkg::DEF_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_in_valid,
    input  logic                                i_kind,
    input  logic signed [conv5_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_win_valid,
    output conv5_pkg::t_meta                    o_meta,
    output conv5_pkg::t_window                  o_window
);

    import conv5_pkg::*;

    localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int LAG    = 2 * IMAGE_WIDTH + 2;
    localparam int CW     = $clog2(IMAGE_WIDTH);
    localparam int RW     = $clog2(IMAGE_HEIGHT);
    localparam int PW     = $clog2(PIXELS + LAG);
    localparam int MW     = LINES * SAMPLE_W;

    logic [CW-1:0] r_col, n_col;
    logic [PW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_ocol, n_ocol;
    logic [RW-1:0] r_orow, n_orow;

    logic                r_v1;
    logic [SAMPLE_W-1:0] r_s1;
    logic [CW-1:0]       r_addr1;
    t_meta               r_meta1;
    logic                r_v2;
    t_meta               r_meta2;
    t_window             r_win;

    logic                accept, in_frame, take, emit, last;
    logic [SAMPLE_W-1:0] s;
    t_meta               meta;
    logic [MW-1:0]       rd_data;
    logic [MW-1:0]       wr_data;
    logic [K-1:0][SAMPLE_W-1:0] col_vec;

    always_comb begin
        accept   = i_in_valid & i_en;
        in_frame = r_pos < PW'(PIXELS);
        // a flush word while pixels are still due is dropped
        take     = accept & ~(in_frame & i_kind);
        emit     = r_pos >= PW'(LAG);
        last     = emit && (r_orow == RW'(IMAGE_HEIGHT - 1)) &&
                   (r_ocol == CW'(IMAGE_WIDTH - 1));
        s        = (in_frame && !i_kind) ? i_sample : '0;

        meta.emit        = emit;
        meta.last        = last;
        meta.row_mask[0] = r_orow >= RW'(2);
        meta.row_mask[1] = r_orow >= RW'(1);
        meta.row_mask[2] = 1'b1;
        meta.row_mask[3] = r_orow <= RW'(IMAGE_HEIGHT - 2);
        meta.row_mask[4] = r_orow <= RW'(IMAGE_HEIGHT - 3);
        meta.col_mask[0] = r_ocol >= CW'(2);
        meta.col_mask[1] = r_ocol >= CW'(1);
        meta.col_mask[2] = 1'b1;
        meta.col_mask[3] = r_ocol <= CW'(IMAGE_WIDTH - 2);
        meta.col_mask[4] = r_ocol <= CW'(IMAGE_WIDTH - 3);

        if (last) begin
            n_col  = '0;
            n_pos  = '0;
            n_ocol = '0;
            n_orow = '0;
        end else begin
            n_col  = (r_col == CW'(IMAGE_WIDTH - 1)) ? '0 : r_col + CW'(1);
            n_pos  = r_pos + PW'(1);
            n_ocol = r_ocol;
            n_orow = r_orow;
            if (emit) begin
                if (r_ocol == CW'(IMAGE_WIDTH - 1)) begin
                    n_ocol = '0;
                    n_orow = r_orow + RW'(1);
                end else begin
                    n_ocol = r_ocol + CW'(1);
                end
            end
        end
    end

    // column through the line memory: slot 0 is the previous line
    always_comb begin
        col_vec[K-1] = r_s1;
        for (int k = 0; k < LINES; k++) begin
            col_vec[LINES-1-k] = rd_data[k*SAMPLE_W +: SAMPLE_W];
        end
        wr_data = {rd_data[MW-SAMPLE_W-1:0], r_s1};
    end

    conv5_ram #(
        .WIDTH (MW),
        .DEPTH (IMAGE_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_en & r_v1),
        .i_wr_addr (r_addr1),
        .i_wr_data (wr_data),
        .i_rd_en   (take),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_pos   <= '0;
            r_ocol  <= '0;
            r_orow  <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_win   <= '0;
        end else begin
            if (take) begin
                r_col  <= n_col;
                r_pos  <= n_pos;
                r_ocol <= n_ocol;
                r_orow <= n_orow;
            end
            if (i_en) begin
                r_v1 <= take;
                r_v2 <= r_v1;
                if (r_v1) begin
                    for (int r = 0; r < K; r++) begin
                        for (int c = 0; c < K - 1; c++) begin
                            r_win[r*K+c] <= r_win[r*K+c+1];
                        end
                        r_win[r*K+K-1] <= col_vec[r];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1    <= s;
            r_addr1 <= r_col;
            r_meta1 <= meta;
        end
        if (i_en) begin
            r_meta2 <= r_meta1;
        end
    end

    assign o_win_valid = r_v2;
    assign o_meta      = r_meta2;
    assign o_window    = r_win;

endmodule

[hdl/conv5_mac.sv]
// ----------------------------------------------------------------------------
// conv5_mac
// Masked tap products, registered adder tree, rounding, saturation, ReLU.
// ----------------------------------------------------------------------------
module conv5_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  conv5_pkg::t_meta                      i_meta,
    input  conv5_pkg::t_window                    i_window,
    input  conv5_pkg::t_coef_set                  i_coef,
    input  logic signed [conv5_pkg::BIAS_W-1:0]   i_bias,
    input  logic                                  i_relu,
    output logic                                  o_valid,
    output logic signed [conv5_pkg::SAMPLE_W-1:0] o_value,
    output logic                                  o_last,
    output logic                                  o_sat
);

    import conv5_pkg::*;

    localparam int Q_W = ACC_W - FRAC_SH;

    logic signed [PROD_W-1:0]    prod [TAPS];
    logic signed [PROD_W-1:0]    r_prod [TAPS];
    logic signed [ROW_SUM_W-1:0] row_sum [K];
    logic signed [ROW_SUM_W-1:0] r_row_sum [K];
    logic signed [ACC_W-1:0]     total;
    logic signed [ACC_W-1:0]     r_total;
    logic signed [ACC_W-1:0]     rounded;
    logic signed [Q_W-1:0]       q;
    logic signed [SAMPLE_W-1:0]  clipped;
    logic                        sat;

    logic  r_v3, r_v4, r_v5;
    t_meta r_m3, r_m4, r_m5;

    logic                        r_o_valid;
    logic signed [SAMPLE_W-1:0]  r_o_value;
    logic                        r_o_last;
    logic                        r_o_sat;

    always_comb begin
        for (int r = 0; r < K; r++) begin
            for (int c = 0; c < K; c++) begin
                prod[r*K+c] = $signed(i_window[r*K+c]) *
                              $signed(i_coef[r][COEF_W*c +: COEF_W]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < K; r++) begin
            row_sum[r] = '0;
            for (int c = 0; c < K; c++) begin
                row_sum[r] = row_sum[r] + ROW_SUM_W'(r_prod[r*K+c]);
            end
        end
        total = ACC_W'(i_bias);
        for (int r = 0; r < K; r++) begin
            total = total + ACC_W'(r_row_sum[r]);
        end
    end

    // floor((sum + half) / 2^10), clip to 16 bits, then optional clamp
    always_comb begin
        rounded = r_total + ACC_W'(1 << (FRAC_SH - 1));
        q       = Q_W'(rounded >>> FRAC_SH);
        sat     = 1'b0;
        clipped = q[SAMPLE_W-1:0];
        if (q > Q_W'(32767)) begin
            clipped = 16'sh7fff;
            sat     = 1'b1;
        end else if (q < -Q_W'(32768)) begin
            clipped = 16'sh8000;
            sat     = 1'b1;
        end
        if (i_relu && clipped[SAMPLE_W-1]) begin
            clipped = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_v3      <= i_valid;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_o_valid <= r_v5 & r_m5.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < K; r++) begin
                for (int c = 0; c < K; c++) begin
                    r_prod[r*K+c] <= (i_meta.row_mask[r] && i_meta.col_mask[c]) ?
                                     prod[r*K+c] : '0;
                end
                r_row_sum[r] <= row_sum[r];
            end
            r_total   <= total;
            r_m3      <= i_meta;
            r_m4      <= r_m3;
            r_m5      <= r_m4;
            r_o_value <= clipped;
            r_o_last  <= r_m5.last;
            r_o_sat   <= sat;
        end
    end

    assign o_valid = r_o_valid;
    assign o_value = r_o_value;
    assign o_last  = r_o_last;
    assign o_sat   = r_o_sat;

endmodule

[sim/same_padded_conv5x5_stream_tb.sv]
// ----------------------------------------------------------------------------
// same_padded_conv5x5_stream_tb
// Self-checking bench for the 5x5 zero-padded convolution stream. A model of
// the line store, tap window and frame counters predicts each convolved
// pixel. Every delivered result is matched field by field against the oldest
// prediction. Kernel, bias and ReLU settings change only between drained
// phases, corner settings first and random ones after that. Both sides of the
// stream idle at random, and the output side holds off once for a long
// stretch so that the block backs up.
// ----------------------------------------------------------------------------
module same_padded_conv5x5_stream_tb;

    import conv5_pkg::*;

    localparam int FRAME_W        = DEF_WIDTH;
    localparam int FRAME_H        = DEF_HEIGHT;
    localparam int PIXELS         = FRAME_W * FRAME_H;
    localparam int LAG            = 2 * FRAME_W + 2;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int STREAM_ITEMS   = 2000;
    localparam int IDLE_PCT       = 21;

    // index past the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [11:0][SAMPLE_W-1:0] CORNER_SAMPLES = {
        16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h5555,
        16'hAAAA, 16'h0100, 16'hFF00, 16'h7FFE, 16'h8001, 16'h00FF
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
        logic                       sat;
    } conv_result_t;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic                       i_kind      = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample    = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_value;
    logic                       o_last_pixel;
    logic                       o_saturated;
    logic                       i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0]           i_cfg_data  = '0;

    // predictor state
    logic signed [SAMPLE_W-1:0] line_model [LINES*FRAME_W] = '{default: '0};
    logic signed [SAMPLE_W-1:0] win_model [K][K]           = '{default: '{default: '0}};
    int unsigned                pred_in_col  = 0;
    int unsigned                pred_in_row  = 0;
    int unsigned                pred_out_col = 0;
    int unsigned                pred_out_row = 0;
    t_coef_set                  coef_model   = '0;
    logic signed [BIAS_W-1:0]   bias_model   = '0;
    logic                       relu_model   = 1'b0;

    conv_result_t expected_px[$];

    int err_count    = 0;
    int cycle_count  = 0;
    int stream_items = 0;
    bit steady_flow  = 1'b0;
    int rx_hold_req  = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;

    same_padded_conv5x5_stream #(
        .IMAGE_WIDTH  (FRAME_W),
        .IMAGE_HEIGHT (FRAME_H)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_value      (o_value),
        .o_last_pixel (o_last_pixel),
        .o_saturated  (o_saturated),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // output side: random ready, with a long hold-off on request
    always @(posedge i_clk) begin : result_sink
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (rx_hold_seen != rx_hold_req) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = RX_HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : result_check
        conv_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_px.size() == 0) begin
                $error("value: expected no word, actual %0d", o_value);
                err_count++;
            end else begin
                want = expected_px.pop_front();
                if (o_value !== want.value) begin
                    $error("value: expected %0d, actual %0d", want.value, o_value);
                    err_count++;
                end
                if (o_last_pixel !== want.last) begin
                    $error("last_pixel: expected %0b, actual %0b", want.last, o_last_pixel);
                    err_count++;
                end
                if (o_saturated !== want.sat) begin
                    $error("saturated: expected %0b, actual %0b", want.sat, o_saturated);
                    err_count++;
                end
            end
        end
    end

    task automatic predict_conv(input logic kind, input logic [SAMPLE_W-1:0] smp);
        int unsigned                pos;
        int                         yy;
        int                         xx;
        logic signed [SAMPLE_W-1:0] pix;
        logic signed [SAMPLE_W-1:0] column [K];
        logic signed [COEF_W-1:0]   weight;
        longint                     acc;
        longint                     q;
        conv_result_t               res;
        pos = pred_in_row * FRAME_W + pred_in_col;
        pix = '0;
        if (pos < PIXELS) begin
            // flush while pixels are still due is dropped
            if (kind) return;
            pix = smp;
        end
        column[K-1] = pix;
        for (int r = 0; r < LINES; r++) begin
            column[LINES-1-r] = line_model[r*FRAME_W + pred_in_col];
        end
        for (int r = LINES - 1; r > 0; r--) begin
            line_model[r*FRAME_W + pred_in_col] = line_model[(r-1)*FRAME_W + pred_in_col];
        end
        line_model[pred_in_col] = pix;
        for (int r = 0; r < K; r++) begin
            for (int c = 0; c < K - 1; c++) win_model[r][c] = win_model[r][c+1];
            win_model[r][K-1] = column[r];
        end
        pred_in_col++;
        if (pred_in_col >= FRAME_W) begin
            pred_in_col = 0;
            pred_in_row++;
        end
        if (pos < LAG) return;

        acc = longint'(bias_model);
        for (int r = 0; r < K; r++) begin
            yy = int'(pred_out_row) + r - 2;
            if (yy >= 0 && yy < FRAME_H) begin
                for (int c = 0; c < K; c++) begin
                    xx = int'(pred_out_col) + c - 2;
                    if (xx >= 0 && xx < FRAME_W) begin
                        weight = coef_model[r][COEF_W*c +: COEF_W];
                        acc += longint'(win_model[r][c]) * longint'(weight);
                    end
                end
            end
        end
        q = (acc + 512) >>> FRAC_SH;
        res.sat = 1'b0;
        if (q > 32767) begin
            q = 32767;
            res.sat = 1'b1;
        end else if (q < -32768) begin
            q = -32768;
            res.sat = 1'b1;
        end
        if (relu_model && q < 0) q = 0;
        res.value = q[SAMPLE_W-1:0];
        res.last  = (pred_out_row == FRAME_H - 1) && (pred_out_col == FRAME_W - 1);
        expected_px.push_back(res);

        if (res.last) begin
            pred_in_col  = 0;
            pred_in_row  = 0;
            pred_out_col = 0;
            pred_out_row = 0;
        end else begin
            pred_out_col++;
            if (pred_out_col >= FRAME_W) begin
                pred_out_col = 0;
                pred_out_row++;
            end
        end
    endtask

    task automatic send_word(input logic kind, input logic [SAMPLE_W-1:0] smp);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            i_kind     <= 1'($urandom);
            i_sample   <= SAMPLE_W'($urandom);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_sample   <= smp;
        do @(posedge i_clk); while (!o_in_ready);
        predict_conv(kind, smp);
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (expected_px.size() != 0) @(posedge i_clk);
        // words that make no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3, REG_COEF4: coef_model[idx] = data;
            REG_BIAS: bias_model = data[BIAS_W-1:0];
            REG_RELU: relu_model = data[0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input t_coef_set coefs, input logic [BIAS_W-1:0] bias,
                                 input logic relu);
        logic [63:0] noise;
        drain_pipeline();
        noise = {$urandom, $urandom};
        cfg_write(REG_UNUSED, noise[CFG_W-1:0]);
        for (int i = 0; i < K; i++) begin
            cfg_write(CFG_IDX_W'(int'(REG_COEF0) + i), coefs[i]);
        end
        noise = {$urandom, $urandom};
        cfg_write(REG_BIAS, {noise[CFG_W-1:BIAS_W], bias});
        noise = {$urandom, $urandom};
        cfg_write(REG_RELU, {noise[CFG_W-1:1], relu});
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return SAMPLE_W'($urandom_range(512)) - SAMPLE_W'(256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // mostly well-formed frames: pixels while pixels are due, then flushes,
    // with a few stray flushes and pixels mixed in
    task automatic send_stream_chunk(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if (pred_in_row * FRAME_W + pred_in_col < PIXELS) begin
                if ($urandom_range(99) < 3) begin
                    send_word(1'b1, rand_sample());
                end else begin
                    send_word(1'b0, rand_sample());
                    sent++;
                end
            end else begin
                send_word($urandom_range(99) >= 10, rand_sample());
                sent++;
            end
        end
        stream_items += sent;
    endtask

    task automatic test_directed_extremes();
        load_settings(t_coef_set'({K*K{12'h7FF}}), 32'h7FFF_FFFF, 1'b0);
        for (int i = 0; i < 22; i++) begin
            if (i == 3 || i == 11) send_word(1'b1, CORNER_SAMPLES[i]);
            send_word(1'b0, CORNER_SAMPLES[i % 12]);
        end
    endtask

    task automatic test_saturation_corners();
        t_coef_set center_tap;
        center_tap = '0;
        center_tap[2][COEF_W*2 +: COEF_W] = 12'h400;
        load_settings(t_coef_set'({K*K{12'h800}}), 32'h8000_0000, 1'b1);
        send_stream_chunk(120);
        load_settings(t_coef_set'({K*K{12'h800}}), 32'h8000_0000, 1'b0);
        send_stream_chunk(120);
        load_settings('0, 32'h7FFF_FFFF, 1'b0);
        send_stream_chunk(120);
        load_settings(center_tap, '0, 1'b1);
        send_stream_chunk(120);
        load_settings(t_coef_set'({{12{24'h7FF_800}}, 12'h7FF}), '0, 1'b0);
        send_stream_chunk(120);
    endtask

    task automatic test_random_stream();
        t_coef_set        coefs;
        logic [BIAS_W-1:0] bias;
        logic             narrow;
        int               chunk;
        chunk = 0;
        while (stream_items < STREAM_ITEMS) begin
            narrow = ($urandom_range(2) != 0);
            for (int r = 0; r < K; r++) begin
                for (int c = 0; c < K; c++) begin
                    coefs[r][COEF_W*c +: COEF_W] = narrow ?
                        COEF_W'($urandom_range(127)) - COEF_W'(64) : COEF_W'($urandom);
                end
            end
            bias = $urandom;
            if ($urandom_range(3) != 0) bias = BIAS_W'($signed(bias) >>> 11);
            load_settings(coefs, bias, 1'($urandom));
            steady_flow = (chunk == 2);
            // output stalls long enough for the input to back up
            if (chunk == 4) rx_hold_req++;
            send_stream_chunk($urandom_range(300, 100));
            chunk++;
        end
        steady_flow = 1'b0;
    endtask

    initial begin : main_seq
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_saturation_corners();
        test_random_stream();
        drain_pipeline();
        if (err_count == 0 && expected_px.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
